// File: rtl/life_automaton_grid_step_assert.svh
// Assertion macros for the life grid stepper.
// Expects clk and rst_n in the scope of each use.
`ifndef LIFE_AUTOMATON_GRID_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_STEP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lags_pkg.sv
// Shared constants, codes and types for the life grid stepper.
// No dependencies.
package lags_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int CELL_AW = XW + YW;
  localparam int CELLS   = 1 << CELL_AW;
  localparam int ROWS    = 1 << YW;
  localparam int SW_W    = $clog2(MAX_WIDTH + 1);
  localparam int SH_W    = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 2;
  localparam int COORD_W   = 6;
  localparam int FADE_W    = 5;

  localparam logic [FADE_W-1:0] FADE_FULL       = 5'd20;
  localparam logic [CFG_W-1:0]  GRID_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [MAX_WIDTH-1:0] row_t;

  // Three old rows around the row being advanced
  typedef struct packed {
    row_t above;
    row_t here;
    row_t below;
  } window_t;

endpackage

// File: rtl/lags_if.sv
// Valid/ready channel interfaces of the life grid stepper.
// Depends on lags_pkg.
interface lags_in_if;
  logic                             valid;
  logic                             ready;
  logic [lags_pkg::OP_W-1:0]        operation;
  logic [lags_pkg::COORD_W-1:0]     cell_x;
  logic [lags_pkg::COORD_W-1:0]     cell_y;
  logic                             cell_value;

  modport source (output valid, operation, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, operation, cell_x, cell_y, cell_value, output ready);
endinterface

interface lags_out_if;
  logic                             valid;
  logic                             ready;
  logic                             alive;
  logic [lags_pkg::FADE_W-1:0]      fade_level;
  logic                             bad_coordinate;

  modport source (output valid, alive, fade_level, bad_coordinate, input ready);
  modport sink   (input valid, alive, fade_level, bad_coordinate, output ready);
endinterface

// File: rtl/life_automaton_grid_step.sv
// Top level of the life grid stepper: sequencer, row buffers, result register.
// Depends on lags_pkg, lags_if, lags_ram, lags_cell_unit and the assertion header.
//
//  channel   dir  handshake      word
//  in_chan   in   valid/ready    operation, cell_x, cell_y, cell_value
//  out_chan  out  valid/ready    alive, fade_level, bad_coordinate
//  cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// A clear zeroes every fade word and alive row; a bad coordinate skips the RAM access.
// An advance makes one pass of the shared cell unit per active cell, plus
// a row load and a row write-back per active row.
// After reset a clearing pass over all 4096 fade words zeroes both stores; in_chan.ready stays low.
// in_chan.ready is high only when the sequencer is idle; a result waiting on
// out_chan holds the sequencer in its final state.
`include "life_automaton_grid_step_assert.svh"

module life_automaton_grid_step (
  input  logic                              clk,
  input  logic                              rst_n,
  lags_in_if.sink                           in_chan,
  lags_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [lags_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lags_pkg::CFG_W-1:0]        cfg_data
);

  localparam int XW      = lags_pkg::XW;
  localparam int YW      = lags_pkg::YW;
  localparam int CELL_AW = lags_pkg::CELL_AW;
  localparam int FADE_W  = lags_pkg::FADE_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WR   = 9'b000000010,
    S_RD   = 9'b000000100,
    S_LD1  = 9'b000001000,
    S_LDN  = 9'b000010000,
    S_CELL = 9'b000100000,
    S_TAIL = 9'b001000000,
    S_CLR  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [lags_pkg::CFG_W-1:0]   grid_width_r, grid_height_r;
  logic [XW-1:0]                x_r, x_nxt;
  logic [YW-1:0]                y_r, y_nxt;
  logic                         val_r, val_nxt;
  logic [CELL_AW-1:0]           idx_r, idx_nxt;
  logic                         clr_op_r, clr_op_nxt;
  lags_pkg::row_t               prev_r, prev_nxt, cur_r, cur_nxt, nxt_r, nxt_nxt;
  lags_pkg::row_t               newrow_r, newrow_nxt;
  logic                         d_valid_r, d_valid_nxt;
  logic [XW-1:0]                d_x_r, d_x_nxt;
  logic                         d_bit_r, d_bit_nxt;
  logic                         res_alive_r, res_alive_nxt;
  logic [FADE_W-1:0]            res_fade_r, res_fade_nxt;
  logic                         res_bad_r, res_bad_nxt;
  logic                         out_valid_r;
  logic                         out_alive_r;
  logic [FADE_W-1:0]            out_fade_r;
  logic                         out_bad_r;

  logic [lags_pkg::SW_W-1:0]    act_w;
  logic [lags_pkg::SH_W-1:0]    act_h;
  lags_pkg::row_t               col_mask;
  lags_pkg::row_t               wr_row;
  lags_pkg::window_t            win;
  logic                         in_acc, coord_bad, size_zero, out_load;
  logic                         cu_bit;
  logic [FADE_W-1:0]            cu_fade;

  logic                         ar_we, ar_re;
  logic [YW-1:0]                ar_waddr, ar_raddr;
  lags_pkg::row_t               ar_wdata, ar_rdata;
  logic                         fr_we, fr_re;
  logic [CELL_AW-1:0]           fr_waddr, fr_raddr;
  logic [FADE_W-1:0]            fr_wdata, fr_rdata;

  // Alive bits, one row per word
  lags_ram #(.DEPTH(lags_pkg::ROWS), .WIDTH(lags_pkg::MAX_WIDTH)) u_alive_ram (
    .clk   (clk),
    .we    (ar_we),
    .waddr (ar_waddr),
    .wdata (ar_wdata),
    .re    (ar_re),
    .raddr (ar_raddr),
    .rdata (ar_rdata)
  );

  // Fade counters, one cell per word, address {row, column}
  lags_ram #(.DEPTH(lags_pkg::CELLS), .WIDTH(FADE_W)) u_fade_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .re    (fr_re),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  assign win.above = prev_r;
  assign win.here  = cur_r;
  assign win.below = nxt_r;

  lags_cell_unit u_cell_unit (
    .win        (win),
    .col_mask   (col_mask),
    .col        (x_r),
    .old_fade   (fr_rdata),
    .fade_alive (d_bit_r),
    .next_alive (cu_bit),
    .next_fade  (cu_fade)
  );

  assign act_w = (int'(grid_width_r) > lags_pkg::MAX_WIDTH) ?
                 lags_pkg::SW_W'(lags_pkg::MAX_WIDTH) : lags_pkg::SW_W'(grid_width_r);
  assign act_h = (int'(grid_height_r) > lags_pkg::MAX_HEIGHT) ?
                 lags_pkg::SH_W'(lags_pkg::MAX_HEIGHT) : lags_pkg::SH_W'(grid_height_r);

  always_comb begin
    for (int i = 0; i < lags_pkg::MAX_WIDTH; i++) begin
      col_mask[i] = (i < int'(act_w));
    end
  end

  always_comb begin
    wr_row       = ar_rdata;
    wr_row[x_r]  = val_r;
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign coord_bad     = (int'(in_chan.cell_x) >= int'(act_w)) ||
                         (int'(in_chan.cell_y) >= int'(act_h));
  assign size_zero     = (act_w == '0) || (act_h == '0);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    clr_op_nxt    = clr_op_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    newrow_nxt    = newrow_r;
    res_alive_nxt = res_alive_r;
    res_fade_nxt  = res_fade_r;
    res_bad_nxt   = res_bad_r;
    d_valid_nxt   = 1'b0;
    d_x_nxt       = x_r;
    d_bit_nxt     = cu_bit;
    ar_we         = 1'b0;
    ar_waddr      = y_r;
    ar_wdata      = newrow_r;
    ar_re         = 1'b0;
    ar_raddr      = y_r;
    // Fade write-back follows the neighbor count in the next cycle
    fr_we         = d_valid_r;
    fr_waddr      = {y_r, d_x_r};
    fr_wdata      = cu_fade;
    fr_re         = 1'b0;
    fr_raddr      = {y_r, x_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt         = XW'(in_chan.cell_x);
          y_nxt         = YW'(in_chan.cell_y);
          val_nxt       = in_chan.cell_value;
          res_alive_nxt = 1'b0;
          res_fade_nxt  = '0;
          res_bad_nxt   = 1'b0;
          unique case (lags_pkg::op_t'(in_chan.operation)) inside
            lags_pkg::OP_WRITE, lags_pkg::OP_READ: begin
              if (coord_bad) begin
                res_bad_nxt = 1'b1;
                state_nxt   = S_DONE;
              end else begin
                ar_re    = 1'b1;
                ar_raddr = YW'(in_chan.cell_y);
                fr_re    = 1'b1;
                fr_raddr = {YW'(in_chan.cell_y), XW'(in_chan.cell_x)};
                state_nxt = (lags_pkg::op_t'(in_chan.operation) == lags_pkg::OP_WRITE) ?
                            S_WR : S_RD;
              end
            end
            lags_pkg::OP_ADVANCE: begin
              if (size_zero) begin
                state_nxt = S_DONE;
              end else begin
                y_nxt     = '0;
                prev_nxt  = '0;
                ar_re     = 1'b1;
                ar_raddr  = '0;
                state_nxt = S_LD1;
              end
            end
            lags_pkg::OP_CLEAR: begin
              idx_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        ar_we     = 1'b1;
        ar_waddr  = y_r;
        ar_wdata  = wr_row;
        state_nxt = S_DONE;
      end
      S_RD: begin
        res_alive_nxt = ar_rdata[x_r];
        res_fade_nxt  = fr_rdata;
        state_nxt     = S_DONE;
      end
      S_LD1: begin
        cur_nxt    = ar_rdata;
        newrow_nxt = ar_rdata;
        ar_re      = 1'b1;
        ar_raddr   = y_r + 1'b1;
        state_nxt  = S_LDN;
      end
      S_LDN: begin
        // Rows below the active height count as dead
        nxt_nxt   = (int'(y_r) + 1 < int'(act_h)) ? ar_rdata : '0;
        x_nxt     = '0;
        state_nxt = S_CELL;
      end
      S_CELL: begin
        fr_re             = 1'b1;
        fr_raddr          = {y_r, x_r};
        d_valid_nxt       = 1'b1;
        newrow_nxt[x_r]   = cu_bit;
        if (int'(x_r) + 1 == int'(act_w)) begin
          state_nxt = S_TAIL;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      S_TAIL: begin
        ar_we      = 1'b1;
        ar_waddr   = y_r;
        ar_wdata   = newrow_r;
        // Advance the window with old contents, not the rewritten row
        prev_nxt   = cur_r;
        cur_nxt    = nxt_r;
        newrow_nxt = nxt_r;
        y_nxt      = y_r + 1'b1;
        if (int'(y_r) + 1 >= int'(act_h)) begin
          state_nxt = S_DONE;
        end else begin
          ar_re     = 1'b1;
          ar_raddr  = y_r + YW'(2);
          state_nxt = S_LDN;
        end
      end
      S_CLR: begin
        fr_we    = 1'b1;
        fr_waddr = idx_r;
        fr_wdata = '0;
        if (idx_r[XW-1:0] == '0) begin
          ar_we    = 1'b1;
          ar_waddr = idx_r[CELL_AW-1:XW];
          ar_wdata = '0;
        end
        if (idx_r == '1) begin
          state_nxt = clr_op_r ? S_DONE : S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      idx_r         <= '0;
      clr_op_r      <= 1'b0;
      d_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= lags_pkg::GRID_SIZE_RESET;
      grid_height_r <= lags_pkg::GRID_SIZE_RESET;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      clr_op_r  <= clr_op_nxt;
      d_valid_r <= d_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (lags_pkg::cfg_idx_t'(cfg_index))
          lags_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          lags_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          default: grid_width_r <= grid_width_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    val_r       <= val_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    newrow_r    <= newrow_nxt;
    d_x_r       <= d_x_nxt;
    d_bit_r     <= d_bit_nxt;
    res_alive_r <= res_alive_nxt;
    res_fade_r  <= res_fade_nxt;
    res_bad_r   <= res_bad_nxt;
    if (out_load) begin
      out_alive_r <= res_alive_r;
      out_fade_r  <= res_fade_r;
      out_bad_r   <= res_bad_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.alive          = out_alive_r;
  assign out_chan.fade_level     = out_fade_r;
  assign out_chan.bad_coordinate = out_bad_r;

  `LAGS_ASSERT_NEXT(a_busy_after_accept, in_acc, state_r != S_IDLE,
                    "sequencer still idle after accepting a word")
  `LAGS_ASSERT_SAME(a_bad_word_zero, out_valid_r && out_bad_r,
                    !out_alive_r && (out_fade_r == '0), "bad coordinate word carries cell data")
  `LAGS_ASSERT_SAME(a_fade_range, out_valid_r, out_fade_r <= lags_pkg::FADE_FULL,
                    "fade level above full scale")
  `LAGS_ASSERT_SAME(a_col_in_range, state_r == S_CELL, int'(x_r) < int'(act_w),
                    "advance column beyond active width")

endmodule

// File: rtl/lags_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lags_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lags_cell_unit.sv
// Shared cell unit: neighbor count and B3/S23 rule for one column,
// plus the fade counter update. Depends on lags_pkg.
module lags_cell_unit (
  input  lags_pkg::window_t             win,
  input  lags_pkg::row_t                col_mask,
  input  logic [lags_pkg::XW-1:0]       col,
  input  logic [lags_pkg::FADE_W-1:0]   old_fade,
  input  logic                          fade_alive,
  output logic                          next_alive,
  output logic [lags_pkg::FADE_W-1:0]   next_fade
);

  localparam int PW = lags_pkg::MAX_WIDTH + 2;

  logic [PW-1:0] pad_a, pad_h, pad_b;
  logic [2:0]    tap_a, tap_h, tap_b;
  logic [3:0]    count;

  // Pad one dead column on each side so the three taps never run off the row
  assign pad_a = {1'b0, win.above & col_mask, 1'b0};
  assign pad_h = {1'b0, win.here  & col_mask, 1'b0};
  assign pad_b = {1'b0, win.below & col_mask, 1'b0};

  assign tap_a = 3'(pad_a >> col);
  assign tap_h = 3'(pad_h >> col);
  assign tap_b = 3'(pad_b >> col);

  assign count = 4'(tap_a[0]) + 4'(tap_a[1]) + 4'(tap_a[2])
               + 4'(tap_h[0]) + 4'(tap_h[2])
               + 4'(tap_b[0]) + 4'(tap_b[1]) + 4'(tap_b[2]);

  assign next_alive = (count == 4'd3) || (tap_h[1] && (count == 4'd2));

  always_comb begin
    if (fade_alive) begin
      next_fade = lags_pkg::FADE_FULL;
    end else if (old_fade != '0) begin
      next_fade = old_fade - 1'b1;
    end else begin
      next_fade = '0;
    end
  end

endmodule
